/* src/vru_pkg.sv */
// ----------------------------------------------------------------------------
// Vector refraction unit package
// Shared widths and default sizes for the refraction pipeline.
// ----------------------------------------------------------------------------
package vru_pkg;

  // Default component format, Q2.14.
  localparam int COMP_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF = 14;

  // The direction is prescaled into this fixed magnitude width before
  // normalisation, with its largest component brought to bit SCALE_MSB.
  localparam int MAG_W     = 32;
  localparam int SCALE_MSB = 30;
  localparam int SHIFT_W   = $clog2(MAG_W);

endpackage

/* src/vru_isqrt.sv */
// ----------------------------------------------------------------------------
// Pipelined integer square root
// One result bit per stage, floored, with a sideband word carried alongside.
// ----------------------------------------------------------------------------
module vru_isqrt #(
  parameter int IW = 2 * vru_pkg::MAG_W,
  parameter int SW = 1
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  logic [IW-1:0]   radicand,
  input  logic [SW-1:0]   in_side,
  output logic            out_valid,
  output logic [IW/2-1:0] root,
  output logic [SW-1:0]   out_side
);

  localparam int STEPS = IW / 2;

  logic          vld    [STEPS];
  logic [IW-1:0] rem_r  [STEPS];
  logic [IW-1:0] res_r  [STEPS];
  logic [SW-1:0] side_r [STEPS];

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    localparam logic [IW-1:0] BIT = {{(IW-1){1'b0}}, 1'b1} << (IW - 2 - 2 * k);

    logic          v_in;
    logic [IW-1:0] rem_in;
    logic [IW-1:0] res_in;
    logic [SW-1:0] side_in;
    logic [IW-1:0] trial;
    logic          ge;
    logic [IW-1:0] rem_out;
    logic [IW-1:0] res_out;

    // The first stage takes the beat straight from the ports.
    if (k == 0) begin : g_first
      assign v_in    = in_valid;
      assign rem_in  = radicand;
      assign res_in  = '0;
      assign side_in = in_side;
    end else begin : g_next
      assign v_in    = vld[k-1];
      assign rem_in  = rem_r[k-1];
      assign res_in  = res_r[k-1];
      assign side_in = side_r[k-1];
    end

    // One restoring step: try to subtract the current trial value.
    assign trial   = res_in + BIT;
    assign ge      = rem_in >= trial;
    assign rem_out = ge ? rem_in - trial : rem_in;
    assign res_out = ge ? (res_in >> 1) + BIT : res_in >> 1;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= rem_out;
        res_r[k]  <= res_out;
        side_r[k] <= side_in;
      end
    end
  end

  assign out_valid = vld[STEPS-1];
  assign root      = res_r[STEPS-1][IW/2-1:0];
  assign out_side  = side_r[STEPS-1];

endmodule

/* src/vru_div3.sv */
// ----------------------------------------------------------------------------
// Three-lane pipelined normalising divider
// Computes round((num << FW) / den) for three numerators that share one
// denominator, one quotient bit per stage.
// ----------------------------------------------------------------------------
module vru_div3 #(
  parameter int AW = vru_pkg::MAG_W,
  parameter int LW = vru_pkg::MAG_W,
  parameter int FW = vru_pkg::FRAC_BITS_DEF,
  parameter int SW = 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [2:0][AW-1:0]   num,
  input  logic [LW-1:0]        den,
  input  logic [SW-1:0]        in_side,
  output logic                 out_valid,
  output logic [2:0][FW:0]     quo,
  output logic [SW-1:0]        out_side
);

  localparam int STEPS = FW + 1;
  localparam int RW    = LW + FW + 1;

  logic                 vld    [STEPS];
  logic [2:0][RW-1:0]   rem_r  [STEPS];
  logic [2:0][FW:0]     quo_r  [STEPS];
  logic [LW-1:0]        den_r  [STEPS];
  logic [SW-1:0]        side_r [STEPS];

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    logic               v_in;
    logic [2:0][RW-1:0] rem_in;
    logic [2:0][FW:0]   quo_in;
    logic [LW-1:0]      den_in;
    logic [SW-1:0]      side_in;
    logic [RW-1:0]      dshift;
    logic [2:0][RW-1:0] rem_out;
    logic [2:0][FW:0]   quo_out;

    // The first stage forms the rounded numerator (num << FW) + den / 2.
    if (k == 0) begin : g_first
      always_comb begin
        for (int i = 0; i < 3; i++) begin
          rem_in[i] = (RW'(num[i]) << FW) + RW'(den >> 1);
        end
      end
      assign v_in    = in_valid;
      assign quo_in  = '0;
      assign den_in  = den;
      assign side_in = in_side;
    end else begin : g_next
      assign v_in    = vld[k-1];
      assign rem_in  = rem_r[k-1];
      assign quo_in  = quo_r[k-1];
      assign den_in  = den_r[k-1];
      assign side_in = side_r[k-1];
    end

    // Restoring step against the denominator aligned to this quotient bit.
    assign dshift = RW'(den_in) << (FW - k);

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        if (rem_in[i] >= dshift) begin
          rem_out[i] = rem_in[i] - dshift;
          quo_out[i] = {quo_in[i][FW-1:0], 1'b1};
        end else begin
          rem_out[i] = rem_in[i];
          quo_out[i] = {quo_in[i][FW-1:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= rem_out;
        quo_r[k]  <= quo_out;
        den_r[k]  <= den_in;
        side_r[k] <= side_in;
      end
    end
  end

  assign out_valid = vld[STEPS-1];
  assign quo       = quo_r[STEPS-1];
  assign out_side  = side_r[STEPS-1];

endmodule

/* src/vector_refraction_unit.sv */
// Beats keep their order from input to result; default components are Q2.14.
// Throughput: one beat per cycle while the result side is not stalled; the two square
// roots and the divider are fully pipelined, one result bit per stage.
// A stall on the result side freezes every stage together, so nothing is lost.
// Reset clears all valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
// Vector refraction unit
// Refracts a ray direction at a surface by the vector form of Snell's law,
// normalising the direction first and flagging total internal reflection.
// ----------------------------------------------------------------------------
module vector_refraction_unit #(
  parameter int COMP_BITS = vru_pkg::COMP_BITS_DEF,
  parameter int FRAC_BITS = vru_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [COMP_BITS-1:0] dir_x,
  input  logic signed [COMP_BITS-1:0] dir_y,
  input  logic signed [COMP_BITS-1:0] dir_z,
  input  logic signed [COMP_BITS-1:0] normal_x,
  input  logic signed [COMP_BITS-1:0] normal_y,
  input  logic signed [COMP_BITS-1:0] normal_z,
  input  logic        [COMP_BITS-1:0] index_ratio,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [COMP_BITS-1:0] refr_x,
  output logic signed [COMP_BITS-1:0] refr_y,
  output logic signed [COMP_BITS-1:0] refr_z,
  output logic                        refracts
);
  import vru_pkg::*;

  localparam int C   = COMP_BITS;
  localparam int F   = FRAC_BITS;
  localparam int BW  = (C > F) ? C : F;
  localparam int QW  = F + 1;            // unit magnitude, up to 1.0
  localparam int UW  = F + 2;            // signed unit value
  localparam int PW  = QW + C;           // unit times component
  localparam int DSW = BW + 4;           // dot product sum
  localparam int RCW = (2 * C > F + 5) ? 2 * C : F + 5;
  localparam int R2W = F + 4;            // saturated ratio squared
  localparam int TW  = BW + 3;           // tangential term
  localparam int RTW = R2W + QW;
  localparam int TRP = TW + C;           // tangential term times ratio
  localparam int TRW = TRP + 1;
  localparam int VW  = TRW + 1;
  localparam int SW2 = 2 * F + 2;        // discriminant radicand width

  localparam logic signed [DSW-1:0] D_ONE  = $signed(DSW'(1) << F);
  localparam logic signed [DSW-1:0] D_MONE = -D_ONE;
  localparam logic [QW-1:0]         Q_ONE  = QW'(1) << F;
  localparam logic [RTW-1:0]        RT_ONE = RTW'(1) << F;
  localparam logic [RCW-1:0]        R2_MAX = (RCW'(1) << (F + 4)) - RCW'(1);
  localparam logic signed [VW-1:0]  O_MAX  = $signed((VW'(1) << (C - 1)) - VW'(1));
  localparam logic signed [VW-1:0]  O_MIN  = -O_MAX - VW'(1);

  typedef struct packed {
    logic [2:0][MAG_W-1:0] a;
    logic [2:0]            dneg;
    logic [2:0][C-1:0]     n;
    logic [C-1:0]          r;
    logic                  zero;
  } side_len_t;

  typedef struct packed {
    logic [2:0]        dneg;
    logic [2:0][C-1:0] n;
    logic [C-1:0]      r;
    logic              zero;
  } side_div_t;

  typedef struct packed {
    logic [2:0][TRW-1:0] tr;
    logic [2:0][C-1:0]   n;
    logic                ok;
  } side_sq_t;

  // Whole-pipeline advance: move when the result register is free or taken.
  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // --------------------------------------------------------------------------
  // Stage 1: component magnitudes and signs.
  logic [2:0][C-1:0] din, nin, dmag_c;
  logic              s1_v;
  logic [2:0][C-1:0] s1_dmag, s1_n;
  logic [2:0]        s1_dneg;
  logic [C-1:0]      s1_r;

  assign din = {dir_z, dir_y, dir_x};
  assign nin = {normal_z, normal_y, normal_x};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dmag_c[i] = din[i][C-1] ? (~din[i] + 1'b1) : din[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (adv) begin
      s1_v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_dmag <= dmag_c;
      s1_dneg <= {din[2][C-1], din[1][C-1], din[0][C-1]};
      s1_n    <= nin;
      s1_r    <= index_ratio;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: exact power-of-two prescale of the direction.
  logic [C-1:0]          mx;
  logic [MAG_W-1:0]      mx_w;
  logic [SHIFT_W-1:0]    msb, sh;
  logic                  s2_v;
  logic [2:0][MAG_W-1:0] s2_a;
  logic [2:0]            s2_dneg;
  logic [2:0][C-1:0]     s2_n;
  logic [C-1:0]          s2_r;
  logic                  s2_zero;

  always_comb begin
    mx = s1_dmag[0];
    if (s1_dmag[1] > mx) mx = s1_dmag[1];
    if (s1_dmag[2] > mx) mx = s1_dmag[2];
    mx_w = MAG_W'(mx);
    msb  = '0;
    for (int b = 0; b < MAG_W; b++) begin
      if (mx_w[b]) msb = SHIFT_W'(b);
    end
    sh = (msb >= SHIFT_W'(SCALE_MSB)) ? '0 : SHIFT_W'(SCALE_MSB) - msb;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (adv) begin
      s2_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        s2_a[i] <= MAG_W'(s1_dmag[i]) << sh;
      end
      s2_dneg <= s1_dneg;
      s2_n    <= s1_n;
      s2_r    <= s1_r;
      s2_zero <= (mx == '0);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: squares of the prescaled components.
  logic                    s3_v;
  logic [2:0][2*MAG_W-1:0] s3_sq;
  side_len_t               s3_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_v <= 1'b0;
    end else if (adv) begin
      s3_v <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        s3_sq[i] <= (2 * MAG_W)'(s2_a[i]) * (2 * MAG_W)'(s2_a[i]);
      end
      s3_side <= '{a: s2_a, dneg: s2_dneg, n: s2_n, r: s2_r, zero: s2_zero};
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: squared length.
  logic               s4_v;
  logic [2*MAG_W-1:0] s4_l2;
  side_len_t          s4_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_v <= 1'b0;
    end else if (adv) begin
      s4_v <= s3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_l2   <= s3_sq[0] + s3_sq[1] + s3_sq[2];
      s4_side <= s3_side;
    end
  end

  // --------------------------------------------------------------------------
  // Length by pipelined square root, then normalisation by division.
  logic             len_v;
  logic [MAG_W-1:0] len;
  side_len_t        len_side;

  vru_isqrt #(
    .IW(2 * MAG_W),
    .SW($bits(side_len_t))
  ) u_len_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (s4_v),
    .radicand (s4_l2),
    .in_side  (s4_side),
    .out_valid(len_v),
    .root     (len),
    .out_side (len_side)
  );

  logic           div_v;
  logic [2:0][F:0] uq;
  side_div_t      div_side;

  vru_div3 #(
    .AW(MAG_W),
    .LW(MAG_W),
    .FW(F),
    .SW($bits(side_div_t))
  ) u_norm_div (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (len_v),
    .num      (len_side.a),
    .den      (len),
    .in_side  ({len_side.dneg, len_side.n, len_side.r, len_side.zero}),
    .out_valid(div_v),
    .quo      (uq),
    .out_side (div_side)
  );

  // --------------------------------------------------------------------------
  // Stage 5: signed unit direction and its products with the normal.
  logic [2:0][C-1:0]       nmag5;
  logic                    s5_v;
  logic [2:0][PW-1:0]      s5_p;
  logic [2:0]              s5_pneg;
  logic signed [2:0][UW-1:0] s5_uv;
  logic [2:0][C-1:0]       s5_n;
  logic [C-1:0]            s5_r;
  logic                    s5_zero;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nmag5[i] = div_side.n[i][C-1] ? (~div_side.n[i] + 1'b1) : div_side.n[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_v <= 1'b0;
    end else if (adv) begin
      s5_v <= div_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        s5_p[i]    <= PW'(uq[i]) * PW'(nmag5[i]);
        s5_pneg[i] <= div_side.dneg[i] ^ div_side.n[i][C-1];
        s5_uv[i]   <= div_side.dneg[i] ? UW'(-$signed({1'b0, uq[i]}))
                                       : UW'($signed({1'b0, uq[i]}));
      end
      s5_n    <= div_side.n;
      s5_r    <= div_side.r;
      s5_zero <= div_side.zero;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 6: rounded dot product, clamped to [-1, 1].
  logic [2:0][PW-1:0]  rnd6;
  logic signed [DSW-1:0] term6 [3];
  logic signed [DSW-1:0] dsum;
  logic signed [UW-1:0]  dt_c;
  logic                  s6_v;
  logic signed [UW-1:0]  s6_dt;
  logic signed [2:0][UW-1:0] s6_uv;
  logic [2:0][C-1:0]     s6_n;
  logic [C-1:0]          s6_r;
  logic                  s6_zero;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rnd6[i]  = (s5_p[i] >> F) + PW'(s5_p[i][F-1]);
      term6[i] = s5_pneg[i] ? -DSW'($signed({1'b0, rnd6[i]}))
                            :  DSW'($signed({1'b0, rnd6[i]}));
    end
    dsum = term6[0] + term6[1] + term6[2];
    if (dsum > D_ONE) begin
      dt_c = UW'(D_ONE);
    end else if (dsum < D_MONE) begin
      dt_c = UW'(D_MONE);
    end else begin
      dt_c = UW'(dsum);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_v <= 1'b0;
    end else if (adv) begin
      s6_v <= s5_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_dt   <= dt_c;
      s6_uv   <= s5_uv;
      s6_n    <= s5_n;
      s6_r    <= s5_r;
      s6_zero <= s5_zero;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 7: dt squared, ratio squared and normal times dt.
  logic [UW-1:0]           dt_neg;
  logic [QW-1:0]           dtmag;
  logic [2:0][C-1:0]       nmag7;
  logic                    s7_v;
  logic [2*QW-1:0]         s7_dsq;
  logic [2*C-1:0]          s7_rsq;
  logic [2:0][PW-1:0]      s7_nd;
  logic [2:0]              s7_ndneg;
  logic signed [2:0][UW-1:0] s7_uv;
  logic [2:0][C-1:0]       s7_n;
  logic [C-1:0]            s7_r;
  logic                    s7_zero;

  assign dt_neg = -s6_dt;
  assign dtmag  = s6_dt[UW-1] ? dt_neg[QW-1:0] : s6_dt[QW-1:0];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nmag7[i] = s6_n[i][C-1] ? (~s6_n[i] + 1'b1) : s6_n[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s7_v <= 1'b0;
    end else if (adv) begin
      s7_v <= s6_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s7_dsq <= (2 * QW)'(dtmag) * (2 * QW)'(dtmag);
      s7_rsq <= (2 * C)'(s6_r) * (2 * C)'(s6_r);
      for (int i = 0; i < 3; i++) begin
        s7_nd[i]    <= PW'(nmag7[i]) * PW'(dtmag);
        s7_ndneg[i] <= s6_n[i][C-1] ^ s6_dt[UW-1];
      end
      s7_uv   <= s6_uv;
      s7_n    <= s6_n;
      s7_r    <= s6_r;
      s7_zero <= s6_zero;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 8: rounding, ratio-squared saturation and the tangential term.
  logic [2*QW-1:0]       dt2f;
  logic [RCW-1:0]        r2f;
  logic [2:0][PW-1:0]    rnd8;
  logic signed [TW-1:0]  mnd [3];
  logic                  s8_v;
  logic [QW-1:0]         s8_dt2;
  logic [R2W-1:0]        s8_r2;
  logic signed [2:0][TW-1:0] s8_t;
  logic [2:0][C-1:0]     s8_n;
  logic [C-1:0]          s8_r;
  logic                  s8_zero;

  always_comb begin
    dt2f = (s7_dsq >> F) + (2 * QW)'(s7_dsq[F-1]);
    r2f  = RCW'(s7_rsq >> F) + RCW'(s7_rsq[F-1]);
    for (int i = 0; i < 3; i++) begin
      rnd8[i] = (s7_nd[i] >> F) + PW'(s7_nd[i][F-1]);
      mnd[i]  = s7_ndneg[i] ? -TW'($signed({1'b0, rnd8[i]}))
                            :  TW'($signed({1'b0, rnd8[i]}));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s8_v <= 1'b0;
    end else if (adv) begin
      s8_v <= s7_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s8_dt2 <= dt2f[QW-1:0];
      s8_r2  <= (r2f > R2_MAX) ? R2_MAX[R2W-1:0] : r2f[R2W-1:0];
      // Each unit component is sign-extended before the subtraction.
      for (int i = 0; i < 3; i++) begin
        s8_t[i] <= TW'($signed(s7_uv[i])) - mnd[i];
      end
      s8_n    <= s7_n;
      s8_r    <= s7_r;
      s8_zero <= s7_zero;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 9: ratio squared times (1 - dt squared), and tangential times ratio.
  logic [2:0][TW-1:0]  tmag;
  logic [QW-1:0]       omd;
  logic                s9_v;
  logic [RTW-1:0]      s9_rtp;
  logic [2:0][TRP-1:0] s9_tr;
  logic [2:0]          s9_tneg;
  logic [2:0][C-1:0]   s9_n;
  logic                s9_zero;

  assign omd = Q_ONE - s8_dt2;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tmag[i] = s8_t[i][TW-1] ? TW'(-s8_t[i]) : TW'(s8_t[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s9_v <= 1'b0;
    end else if (adv) begin
      s9_v <= s8_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s9_rtp <= RTW'(s8_r2) * RTW'(omd);
      for (int i = 0; i < 3; i++) begin
        s9_tr[i]   <= TRP'(tmag[i]) * TRP'(s8_r);
        s9_tneg[i] <= s8_t[i][TW-1];
      end
      s9_n    <= s8_n;
      s9_zero <= s8_zero;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 10: discriminant and its sign; rounded tangential part.
  logic [RTW-1:0]      rtf;
  logic [RTW-1:0]      discr_w;
  logic [2:0][TRP-1:0] rnd10;
  logic                s10_v;
  logic [QW-1:0]       s10_discr;
  side_sq_t            s10_side;

  always_comb begin
    rtf     = (s9_rtp >> F) + RTW'(s9_rtp[F-1]);
    discr_w = RT_ONE - rtf;
    for (int i = 0; i < 3; i++) begin
      rnd10[i] = (s9_tr[i] >> F) + TRP'(s9_tr[i][F-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s10_v <= 1'b0;
    end else if (adv) begin
      s10_v <= s9_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s10_discr <= (rtf < RT_ONE) ? discr_w[QW-1:0] : '0;
      for (int i = 0; i < 3; i++) begin
        s10_side.tr[i] <= s9_tneg[i] ? -$signed({1'b0, rnd10[i]})
                                     :  $signed({1'b0, rnd10[i]});
      end
      s10_side.n  <= s9_n;
      s10_side.ok <= (rtf < RT_ONE) && !s9_zero;
    end
  end

  // --------------------------------------------------------------------------
  // Square root of the discriminant.
  logic     sq_v;
  logic [F:0] sq;
  side_sq_t sq_side;

  vru_isqrt #(
    .IW(SW2),
    .SW($bits(side_sq_t))
  ) u_discr_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (s10_v),
    .radicand (SW2'(s10_discr) << F),
    .in_side  (s10_side),
    .out_valid(sq_v),
    .root     (sq),
    .out_side (sq_side)
  );

  // --------------------------------------------------------------------------
  // Stage 11: normal times the root of the discriminant.
  logic [2:0][C-1:0]   nmag11;
  logic                s11_v;
  logic [2:0][PW-1:0]  s11_ns;
  logic [2:0]          s11_nneg;
  logic [2:0][TRW-1:0] s11_tr;
  logic                s11_ok;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nmag11[i] = sq_side.n[i][C-1] ? (~sq_side.n[i] + 1'b1) : sq_side.n[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s11_v <= 1'b0;
    end else if (adv) begin
      s11_v <= sq_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        s11_ns[i]   <= PW'(nmag11[i]) * PW'(sq);
        s11_nneg[i] <= sq_side.n[i][C-1];
      end
      s11_tr <= sq_side.tr;
      s11_ok <= sq_side.ok;
    end
  end

  // --------------------------------------------------------------------------
  // Result register: final subtraction, saturation and zeroing.
  logic [2:0][PW-1:0]  rnd12;
  logic signed [VW-1:0] nsv [3];
  logic signed [VW-1:0] vsum [3];
  logic [2:0][C-1:0]   sat;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rnd12[i] = (s11_ns[i] >> F) + PW'(s11_ns[i][F-1]);
      nsv[i]   = s11_nneg[i] ? -VW'($signed({1'b0, rnd12[i]}))
                             :  VW'($signed({1'b0, rnd12[i]}));
      vsum[i]  = VW'($signed(s11_tr[i])) - nsv[i];
      if (vsum[i] > O_MAX) begin
        sat[i] = O_MAX[C-1:0];
      end else if (vsum[i] < O_MIN) begin
        sat[i] = O_MIN[C-1:0];
      end else begin
        sat[i] = vsum[i][C-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s11_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      refr_x   <= s11_ok ? sat[0] : '0;
      refr_y   <= s11_ok ? sat[1] : '0;
      refr_z   <= s11_ok ? sat[2] : '0;
      refracts <= s11_ok;
    end
  end

  // --------------------------------------------------------------------------
  // Checks.
  a_tir_zero : assert property (@(posedge clk) disable iff (rst)
    out_valid && !refracts |-> refr_x == '0 && refr_y == '0 && refr_z == '0)
    else $error("reflected beat carries a non-zero vector");

  a_stall_hold : assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(s11_v) && $stable(s10_v) && $stable(s1_v))
    else $error("pipeline moved during a stall");

  a_discr_nonzero : assert property (@(posedge clk) disable iff (rst)
    s10_v && s10_side.ok |-> s10_discr != '0)
    else $error("refraction flagged with a zero discriminant");

  a_reset_empty : assert property (@(posedge clk)
    rst |=> !out_valid && !s1_v)
    else $error("valid bits survive reset");

endmodule

/* sim/vector_refraction_unit_tb.sv */
// ----------------------------------------------------------------------------
// Vector refraction unit testbench
// Drives ray and normal beats into the refraction pipeline with random idling
// on both sides, predicts each result in fixed point and checks it in order.
// ----------------------------------------------------------------------------
module vector_refraction_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW = vru_pkg::COMP_BITS_DEF;
  localparam int FW = vru_pkg::FRAC_BITS_DEF;
  localparam longint ONE_Q = 64'sd1 << FW;
  localparam int N_RANDOM = 1100;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 2 * FW + 47 + 20;

  typedef struct packed {
    logic signed [CW-1:0] dx, dy, dz, nx, ny, nz;
    logic [CW-1:0] eta;
  } ray_t;

  typedef struct packed {
    logic signed [CW-1:0] rx, ry, rz;
    logic ok;
  } refr_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [CW-1:0] dir_x = '0, dir_y = '0, dir_z = '0;
  logic signed [CW-1:0] normal_x = '0, normal_y = '0, normal_z = '0;
  logic [CW-1:0] index_ratio = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [CW-1:0] refr_x, refr_y, refr_z;
  logic refracts;

  ray_t  ray_queue[$];
  refr_t expected_refr[$];
  int    mismatches = 0;
  int    quiet_cycles = 0;
  int    sent_beats = 0;
  bit    calm = 1'b0;
  bit    hold_send = 1'b0;
  bit    stim_done = 1'b0;

  vector_refraction_unit i_dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // Magnitude of a signed value.
  function automatic longint unsigned mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  // Fixed-point product, rounded to nearest with ties away from zero.
  function automatic longint qmul(longint a, longint b);
    longint unsigned p, q;
    p = mag(a) * mag(b);
    q = (p >> FW) + ((p >> (FW - 1)) & 1);
    return ((a < 0) != (b < 0)) ? -longint'(q) : longint'(q);
  endfunction

  // Floored integer square root.
  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic logic signed [CW-1:0] clamp_comp(longint v);
    longint hi, lo;
    hi = (64'sd1 << (CW - 1)) - 1;
    lo = -(64'sd1 << (CW - 1));
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return v[CW-1:0];
  endfunction

  // Expected refracted direction for one ray beat.
  function automatic refr_t refract_ray(ray_t a);
    refr_t o;
    longint d[3], n[3], uv[3], t, v;
    longint unsigned m, len, l2, q;
    longint r, dt, dt2, r2, rt, discr, sq;
    o = '0;
    d[0] = a.dx; d[1] = a.dy; d[2] = a.dz;
    n[0] = a.nx; n[1] = a.ny; n[2] = a.nz;
    r = a.eta;
    m = 0;
    l2 = 0;
    dt = 0;
    for (int i = 0; i < 3; i++) if (mag(d[i]) > m) m = mag(d[i]);
    if (m == 0) return o;
    // Exact power-of-two prescale of the direction.
    while ((m << 1) < (64'd1 << 31)) begin
      m <<= 1;
      for (int i = 0; i < 3; i++) d[i] *= 2;
    end
    for (int i = 0; i < 3; i++) l2 += mag(d[i]) * mag(d[i]);
    len = root_floor(l2);
    for (int i = 0; i < 3; i++) begin
      q = ((mag(d[i]) << FW) + (len >> 1)) / len;
      uv[i] = d[i] < 0 ? -longint'(q) : longint'(q);
    end
    for (int i = 0; i < 3; i++) dt += qmul(uv[i], n[i]);
    if (dt > ONE_Q) dt = ONE_Q;
    if (dt < -ONE_Q) dt = -ONE_Q;
    dt2 = qmul(dt, dt);
    r2 = qmul(r, r);
    if (r2 > (64'sd1 << (FW + 4)) - 1) r2 = (64'sd1 << (FW + 4)) - 1;
    rt = qmul(r2, ONE_Q - dt2);
    discr = ONE_Q - rt;
    if (discr <= 0) return o;
    sq = root_floor(longint'(discr) << FW);
    t = uv[0] - qmul(n[0], dt);
    o.rx = clamp_comp(qmul(t, r) - qmul(n[0], sq));
    t = uv[1] - qmul(n[1], dt);
    o.ry = clamp_comp(qmul(t, r) - qmul(n[1], sq));
    t = uv[2] - qmul(n[2], dt);
    o.rz = clamp_comp(qmul(t, r) - qmul(n[2], sq));
    o.ok = 1'b1;
    return o;
  endfunction

  function automatic logic [CW-1:0] rand_field();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'($signed($urandom_range(0, 64)) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  // Random ray, mostly with a near-unit normal and a ratio around one.
  function automatic ray_t rand_ray();
    ray_t a;
    int ax;
    a.dx = rand_field(); a.dy = rand_field(); a.dz = rand_field();
    if ($urandom_range(0, 9) < 7) begin
      ax = $urandom_range(0, 2);
      a.nx = 16'($signed($urandom_range(0, 12000)) - 6000);
      a.ny = 16'($signed($urandom_range(0, 12000)) - 6000);
      a.nz = 16'($signed($urandom_range(0, 12000)) - 6000);
      if (ax == 0) a.nx = $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
      if (ax == 1) a.ny = $urandom_range(0, 1) ? 16'sd15000 : -16'sd15000;
      if (ax == 2) a.nz = $urandom_range(0, 1) ? 16'sd14000 : -16'sd14000;
      a.eta = 16'($urandom_range(8000, 26000));
    end else begin
      a.nx = rand_field(); a.ny = rand_field(); a.nz = rand_field();
      a.eta = 16'($urandom);
    end
    return a;
  endfunction

  function automatic ray_t mk(int dx, int dy, int dz, int nx, int ny, int nz, int eta);
    ray_t a;
    a.dx = CW'(dx); a.dy = CW'(dy); a.dz = CW'(dz);
    a.nx = CW'(nx); a.ny = CW'(ny); a.nz = CW'(nz);
    a.eta = CW'(eta);
    return a;
  endfunction

  // Stimulus: directed beats, then random ones with a pause to drain.
  initial begin
    ray_queue.push_back(mk(0, 0, 0, 0, 0, 16384, 16384));
    ray_queue.push_back(mk(0, 0, -16384, 0, 0, 16384, 16384));
    ray_queue.push_back(mk(1, 0, 0, 0, 0, 16384, 16384));
    ray_queue.push_back(mk(-32768, -32768, -32768, 0, 16384, 0, 12000));
    ray_queue.push_back(mk(32767, 32767, 32767, 0, 0, -16384, 20000));
    ray_queue.push_back(mk(16384, 0, -100, 0, 0, 16384, 24576));
    ray_queue.push_back(mk(16384, 0, -16384, 0, 0, 16384, 32768));
    ray_queue.push_back(mk(100, -200, 300, 32767, 32767, 32767, 16384));
    ray_queue.push_back(mk(100, -200, 300, -32768, -32768, -32768, 16384));
    ray_queue.push_back(mk(5000, 0, -9000, 0, 0, 16384, 0));
    ray_queue.push_back(mk(5000, 0, -9000, 0, 0, 16384, 65535));
    ray_queue.push_back(mk(-1, 1, -1, 0, -16384, 0, 65535));
    ray_queue.push_back(mk(0, -32768, 0, 0, 16384, 0, 1));
    ray_queue.push_back(mk(32767, -32768, 1, 11585, 11585, 0, 16384));
    ray_queue.push_back(mk(0, 0, -1, 32767, -32768, 16384, 30000));
    repeat (7) @(posedge clk);
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == 500) begin
        wait (ray_queue.size() == 0 && !in_valid);
        hold_send = 1'b1;
        wait (expected_refr.size() == 0);
        @(posedge clk);
        hold_send = 1'b0;
      end
      ray_queue.push_back(rand_ray());
    end
    stim_done = 1'b1;
  end

  // Reset and the final report.
  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    repeat (40) @(posedge clk);
    wait (stim_done && ray_queue.size() == 0 && !in_valid && expected_refr.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_refr.size() == 0) begin
      $display("vector_refraction_unit_tb: done, clean");
    end else begin
      $display("vector_refraction_unit_tb: done, errors");
    end
    $finish;
  end

  // Driver: present the next pending ray beat, idling at random.
  always @(posedge clk) begin
    if (!rst) calm <= (sent_beats >= 200 && sent_beats < 450);
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid && in_ready) begin
        expected_refr.push_back(refract_ray({dir_x, dir_y, dir_z,
            normal_x, normal_y, normal_z, index_ratio}));
        sent_beats <= sent_beats + 1;
      end
      if (ray_queue.size() != 0 && !hold_send && (calm || $urandom_range(0, 99) >= 25)) begin
        ray_t a;
        a = ray_queue.pop_front();
        in_valid <= 1'b1;
        dir_x <= a.dx; dir_y <= a.dy; dir_z <= a.dz;
        normal_x <= a.nx; normal_y <= a.ny; normal_z <= a.nz;
        index_ratio <= a.eta;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: compare each result beat with the oldest expectation.
  always @(posedge clk) begin
    if (!rst) out_ready <= calm || $urandom_range(0, 99) >= 25;
    if (!rst && out_valid && out_ready) begin
      if (expected_refr.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat at %0t", $realtime);
      end else begin
        refr_t e;
        e = expected_refr.pop_front();
        if (e.rx !== refr_x || e.ry !== refr_y || e.rz !== refr_z || e.ok !== refracts) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %0d %0d %0d %0b, got %0d %0d %0d %0b",
                     e.rx, e.ry, e.rz, e.ok, refr_x, refr_y, refr_z, refracts);
        end
      end
    end
  end

  // Watchdog: cycles with no beat on either side.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || rst)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("vector_refraction_unit_tb: done, errors");
      $finish;
    end
  end

endmodule

/* sim.f */
src/vru_pkg.sv
src/vru_isqrt.sv
src/vru_div3.sv
src/vector_refraction_unit.sv
sim/vector_refraction_unit_tb.sv
